// ===== rtl/baro_pressure_temp_compensation_defines.svh =====
// Assertion macros for the compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`ifndef SYNTH
`define BPTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bptc assertion failed");
`define BPTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bptc assertion failed");
`else
`define BPTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bptc_pkg.sv =====
package bptc_pkg;

	localparam int RAW_W      = 24;
	localparam int TK_W       = 25;
	localparam int PP_W       = 26;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRES_A = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRES_B = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRES_C = 4'd3;

	localparam int LAT = 16;

	// linearized temperature, T = nt / 2^48
	localparam int NT_W  = 61;
	// Horner coefficients in nt, all scaled by 2^181 overall
	localparam int A3_W  = 34;
	localparam int A2_W  = 87;
	localparam int A1_W  = 147;
	localparam int A0_W  = 206;
	localparam int M1_W  = NT_W + A3_W;
	localparam int B2_W  = 97;
	localparam int M2_W  = NT_W + B2_W;
	localparam int B1_W  = 160;
	localparam int M3_W  = NT_W + B1_W;
	localparam int SUM_W = 224;

	localparam int ROUND_BIT  = 172;
	localparam int PP_LSB     = 173;
	localparam int PP_OVF_LSB = PP_LSB + PP_W;

	localparam logic signed [63:0] TK_BIAS    = 64'sh0555_C002_8000_0000;
	localparam logic        [31:0] DIV5_MAGIC = 32'hCCCC_CCCD;
	localparam logic [TK_W-1:0]    TK_MAX     = '1;
	localparam logic [PP_W-1:0]    PP_MAX     = '1;

	// alignment delays, counted in stages
	localparam int N_D1 = 4;
	localparam int N_D2 = 8;
	localparam int A2_D = 3;
	localparam int A1_D = 6;
	localparam int A0_D = 9;
	localparam int TK_D = 9;

endpackage

// ===== rtl/bptc_delay.sv =====
module bptc_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] line_q [D];

	always_ff @(posedge clk) begin
		line_q[0] <= din;
		for (int k = 1; k < D; k++) begin
			line_q[k] <= line_q[k-1];
		end
	end

	assign dout = line_q[D-1];
endmodule

// ===== rtl/bptc_mul.sv =====
module bptc_mul #(
	parameter int AW = 61,
	parameter int BW = 34
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	localparam int LW = 32;
	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;
	localparam int PW = AW + BW;

	logic signed [NA*LW-1:0] a_x;
	logic signed [NB*LW-1:0] b_x;
	logic signed [LW:0]      a_l [NA];
	logic signed [LW:0]      b_l [NB];
	logic signed [2*LW+1:0]  pp_s1 [NA][NB];
	logic signed [PW-1:0]    row_c [NA];
	logic signed [PW-1:0]    row_s2 [NA];
	logic signed [PW-1:0]    prod_c;
	logic signed [PW-1:0]    prod_s3;

	assign a_x = (NA*LW)'(a);
	assign b_x = (NB*LW)'(b);

	// low limbs are unsigned, the top limb carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			a_l[i] = (i == NA-1) ? {a_x[NA*LW-1], a_x[i*LW +: LW]} : {1'b0, a_x[i*LW +: LW]};
		end
		for (int j = 0; j < NB; j++) begin
			b_l[j] = (j == NB-1) ? {b_x[NB*LW-1], b_x[j*LW +: LW]} : {1'b0, b_x[j*LW +: LW]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_l[i] * b_l[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (PW'(pp_s1[i][j]) <<< (LW*j));
			end
		end
	end

	always_ff @(posedge clk) begin
		row_s2 <= row_c;
	end

	always_comb begin
		prod_c = '0;
		for (int i = 0; i < NA; i++) begin
			prod_c = prod_c + (row_s2[i] <<< (LW*i));
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod_c;
	end

	assign p = prod_s3;
endmodule

// ===== rtl/bptc_front.sv =====
module bptc_front (
	input  logic                             clk,
	input  logic [bptc_pkg::RAW_W-1:0]       raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]       raw_temperature,
	input  logic [39:0]                      cal_temp,
	input  logic [47:0]                      cal_pres_a,
	input  logic [47:0]                      cal_pres_b,
	input  logic [31:0]                      cal_pres_c,
	output logic signed [bptc_pkg::NT_W-1:0] nt_s3,
	output logic signed [bptc_pkg::A3_W-1:0] a3_s3,
	output logic signed [bptc_pkg::A2_W-1:0] a2_s3,
	output logic signed [bptc_pkg::A1_W-1:0] a1_s4,
	output logic signed [bptc_pkg::A0_W-1:0] a0_s5
);
	import bptc_pkg::*;

	logic        [15:0] t1;
	logic signed [16:0] t2;
	logic signed [7:0]  t3;
	logic signed [16:0] p1m;
	logic signed [16:0] p2m;
	logic signed [7:0]  p3;
	logic signed [7:0]  p4;
	logic signed [16:0] p5;
	logic signed [16:0] p6;
	logic signed [7:0]  p7;
	logic signed [7:0]  p8;
	logic signed [15:0] p9;
	logic signed [7:0]  p10;
	logic signed [7:0]  p11;

	assign t1  = cal_temp[15:0];
	assign t2  = $signed({1'b0, cal_temp[31:16]});
	assign t3  = cal_temp[39:32];
	assign p1m = $signed({cal_pres_a[15], cal_pres_a[15:0]}) - 17'sd16384;
	assign p2m = $signed({cal_pres_a[31], cal_pres_a[31:16]}) - 17'sd16384;
	assign p3  = cal_pres_a[39:32];
	assign p4  = cal_pres_a[47:40];
	assign p5  = $signed({1'b0, cal_pres_b[15:0]});
	assign p6  = $signed({1'b0, cal_pres_b[31:16]});
	assign p7  = cal_pres_b[39:32];
	assign p8  = cal_pres_b[47:40];
	assign p9  = cal_pres_c[15:0];
	assign p10 = cal_pres_c[23:16];
	assign p11 = cal_pres_c[31:24];

	logic signed [24:0] rp_s1;
	logic signed [24:0] d_s1;

	always_ff @(posedge clk) begin
		rp_s1 <= $signed({1'b0, raw_pressure});
		d_s1  <= $signed({1'b0, raw_temperature}) - $signed({1'b0, t1, 8'b0});
	end

	logic signed [41:0] dt2_s2;
	logic signed [49:0] dd_s2;
	logic signed [48:0] psq_s2;
	logic signed [32:0] pp3_s2;
	logic signed [32:0] pp4_s2;
	logic signed [41:0] pa1_s2;
	logic signed [41:0] pa2_s2;
	logic signed [24:0] rp_s2;

	always_ff @(posedge clk) begin
		dt2_s2 <= d_s1 * t2;
		dd_s2  <= d_s1 * d_s1;
		psq_s2 <= rp_s1 * rp_s1;
		pp3_s2 <= rp_s1 * p3;
		pp4_s2 <= rp_s1 * p4;
		pa1_s2 <= rp_s1 * p1m;
		pa2_s2 <= rp_s1 * p2m;
		rp_s2  <= rp_s1;
	end

	logic signed [57:0] ddt3;
	logic signed [41:0] pa1_s3;
	logic signed [41:0] pa2_s3;
	logic signed [64:0] psq9_s3;
	logic signed [56:0] psq10_s3;
	logic signed [56:0] psq11_s3;
	logic signed [24:0] rp_s3;

	assign ddt3 = dd_s2 * t3;

	always_ff @(posedge clk) begin
		nt_s3    <= (NT_W'(dt2_s2) <<< 18) + NT_W'(ddt3);
		a3_s3    <= (A3_W'(p8) <<< 22) + A3_W'(pp4_s2);
		a2_s3    <= (A2_W'(p7) <<< 77) + (A2_W'(pp3_s2) <<< 53);
		psq9_s3  <= psq_s2 * p9;
		psq10_s3 <= psq_s2 * p10;
		psq11_s3 <= psq_s2 * p11;
		pa1_s3   <= pa1_s2;
		pa2_s3   <= pa2_s2;
		rp_s3    <= rp_s2;
	end

	logic signed [81:0]     pcube_s4;
	logic signed [A0_W-1:0] a0p_s4;

	always_ff @(posedge clk) begin
		a1_s4    <= (A1_W'(p6) <<< 127) + (A1_W'(pa2_s3) <<< 104)
			+ (A1_W'(psq10_s3) <<< 85);
		pcube_s4 <= psq11_s3 * rp_s3;
		a0p_s4   <= (A0_W'(p5) <<< 184) + (A0_W'(pa1_s3) <<< 161)
			+ (A0_W'(psq9_s3) <<< 133);
	end

	always_ff @(posedge clk) begin
		a0_s5 <= a0p_s4 + (A0_W'(pcube_s4) <<< 116);
	end
endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Channel   Handshake              Payload
// -------   ---------------------  ------------------------------------------
// request   start, busy            raw_pressure, raw_temperature
// result    done (one-cycle)       temperature_kelvin, pressure_pascal
// config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A shift chain of valid bits carries each accepted request to its done strobe; one
// request per cycle, busy stays low. The depth is set by three chained
// 32x32-limb multiplier units evaluating the pressure polynomial in Horner form.
// Reset clears the valid chain and the calibration registers; data registers
// are not reset. The result side cannot stall, so no request ever waits.
`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [bptc_pkg::RAW_W-1:0]       raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]       raw_temperature,
	output logic                             done,
	output logic [bptc_pkg::TK_W-1:0]        temperature_kelvin,
	output logic [bptc_pkg::PP_W-1:0]        pressure_pascal,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bptc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bptc_pkg::*;

	logic [39:0] cal_temp_q;
	logic [47:0] cal_pres_a_q;
	logic [47:0] cal_pres_b_q;
	logic [31:0] cal_pres_c_q;
	logic [LAT-1:0] valid_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q   <= '0;
			cal_pres_a_q <= '0;
			cal_pres_b_q <= '0;
			cal_pres_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAL_TEMP:   cal_temp_q   <= cfg_data[39:0];
				CFG_CAL_PRES_A: cal_pres_a_q <= cfg_data;
				CFG_CAL_PRES_B: cal_pres_b_q <= cfg_data;
				CFG_CAL_PRES_C: cal_pres_c_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LAT-2:0], start & ~busy};
		end
	end

	logic signed [NT_W-1:0] nt_s3;
	logic signed [A3_W-1:0] a3_s3;
	logic signed [A2_W-1:0] a2_s3;
	logic signed [A1_W-1:0] a1_s4;
	logic signed [A0_W-1:0] a0_s5;

	bptc_front u_front (
		.clk             (clk),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.cal_temp        (cal_temp_q),
		.cal_pres_a      (cal_pres_a_q),
		.cal_pres_b      (cal_pres_b_q),
		.cal_pres_c      (cal_pres_c_q),
		.nt_s3           (nt_s3),
		.a3_s3           (a3_s3),
		.a2_s3           (a2_s3),
		.a1_s4           (a1_s4),
		.a0_s5           (a0_s5)
	);

	// temperature: floor((5*nt + bias) / (5*2^32)) via reciprocal of 5
	logic signed [63:0] tnum;
	logic               tneg_s4;
	logic [31:0]        tq_s4;
	logic               tneg_s5;
	logic [63:0]        tprod_s5;
	logic [TK_W-1:0]    tk_s6;

	assign tnum = (64'(nt_s3) <<< 2) + 64'(nt_s3) + TK_BIAS;

	always_ff @(posedge clk) begin
		tneg_s4  <= tnum[63];
		tq_s4    <= tnum[63:32];
		tneg_s5  <= tneg_s4;
		tprod_s5 <= tq_s4 * DIV5_MAGIC;
		if (tneg_s5) begin
			tk_s6 <= '0;
		end else if (|tprod_s5[63:34+TK_W]) begin
			tk_s6 <= TK_MAX;
		end else begin
			tk_s6 <= tprod_s5[34 +: TK_W];
		end
	end

	// pressure: ((A3*n + A2)*n + A1)*n + A0
	logic [NT_W-1:0] n_d1;
	logic [NT_W-1:0] n_d2;
	logic [A2_W-1:0] a2_d;
	logic [A1_W-1:0] a1_d;
	logic [A0_W-1:0] a0_d;
	logic [TK_W-1:0] tk_d;

	bptc_delay #(.W(NT_W), .D(N_D1)) u_dly_n1 (.clk(clk), .din(nt_s3), .dout(n_d1));
	bptc_delay #(.W(NT_W), .D(N_D2)) u_dly_n2 (.clk(clk), .din(nt_s3), .dout(n_d2));
	bptc_delay #(.W(A2_W), .D(A2_D)) u_dly_a2 (.clk(clk), .din(a2_s3), .dout(a2_d));
	bptc_delay #(.W(A1_W), .D(A1_D)) u_dly_a1 (.clk(clk), .din(a1_s4), .dout(a1_d));
	bptc_delay #(.W(A0_W), .D(A0_D)) u_dly_a0 (.clk(clk), .din(a0_s5), .dout(a0_d));
	bptc_delay #(.W(TK_W), .D(TK_D)) u_dly_tk (.clk(clk), .din(tk_s6), .dout(tk_d));

	logic signed [M1_W-1:0]  m1_s6;
	logic signed [B2_W-1:0]  b2_s7;
	logic signed [M2_W-1:0]  m2_s10;
	logic signed [B1_W-1:0]  b1_s11;
	logic signed [M3_W-1:0]  m3_s14;
	logic signed [SUM_W-1:0] sum_s15;

	bptc_mul #(.AW(NT_W), .BW(A3_W)) u_mul1 (.clk(clk), .a(nt_s3), .b(a3_s3), .p(m1_s6));

	always_ff @(posedge clk) begin
		b2_s7 <= B2_W'(m1_s6) + B2_W'($signed(a2_d));
	end

	bptc_mul #(.AW(NT_W), .BW(B2_W)) u_mul2 (
		.clk (clk),
		.a   ($signed(n_d1)),
		.b   (b2_s7),
		.p   (m2_s10)
	);

	always_ff @(posedge clk) begin
		b1_s11 <= B1_W'(m2_s10) + B1_W'($signed(a1_d));
	end

	bptc_mul #(.AW(NT_W), .BW(B1_W)) u_mul3 (
		.clk (clk),
		.a   ($signed(n_d2)),
		.b   (b1_s11),
		.p   (m3_s14)
	);

	always_ff @(posedge clk) begin
		sum_s15 <= SUM_W'(m3_s14) + SUM_W'($signed(a0_d)) + (SUM_W'(1) <<< ROUND_BIT);
	end

	logic [TK_W-1:0] tk_s16;
	logic [PP_W-1:0] pp_s16;

	always_ff @(posedge clk) begin
		tk_s16 <= tk_d;
		if (sum_s15[SUM_W-1]) begin
			pp_s16 <= '0;
		end else if (|sum_s15[SUM_W-2:PP_OVF_LSB]) begin
			pp_s16 <= PP_MAX;
		end else begin
			pp_s16 <= sum_s15[PP_OVF_LSB-1:PP_LSB];
		end
	end

	assign done               = valid_q[LAT-1];
	assign temperature_kelvin = tk_s16;
	assign pressure_pascal    = pp_s16;

	`BPTC_ASSERT_IMP(a_done_has_request, clk, arst_n, done, $past(start, LAT))
	`BPTC_ASSERT_NXT(a_cold_temp_clamps, clk, arst_n, valid_q[4] && tneg_s5, tk_s6 == '0)
endmodule

// ===== sim/baro_pressure_temp_compensation_test.sv =====
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_test;
	import bptc_pkg::*;

	typedef struct packed {
		logic [TK_W-1:0] kelvin;
		logic [PP_W-1:0] pascal;
	} reading_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [RAW_W-1:0]      raw_pressure;
	logic [RAW_W-1:0]      raw_temperature;
	logic                  done;
	logic [TK_W-1:0]       temperature_kelvin;
	logic [PP_W-1:0]       pressure_pascal;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [39:0] cal_temp;
	logic [47:0] cal_pres_a;
	logic [47:0] cal_pres_b;
	logic [31:0] cal_pres_c;

	reading_t expected_readings[$];
	int       errors;
	int       requests_sent;
	int       readings_checked;
	int       idle_pct;

	baro_pressure_temp_compensation u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.raw_pressure(raw_pressure),
		.raw_temperature(raw_temperature),
		.done(done),
		.temperature_kelvin(temperature_kelvin),
		.pressure_pascal(pressure_pascal),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("%0t timeout", $time);
		$display("TEST FAILED");
		$finish;
	end

	// exact compensation: T = nt / 2^48, pressure held scaled by 2^181
	function automatic reading_t compensate(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt);
		logic signed [255:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
		logic signed [255:0] d, n, p, acc, num, tk;
		reading_t r;
		t1  = $signed({1'b0, cal_temp[15:0]});
		t2  = $signed({1'b0, cal_temp[31:16]});
		t3  = $signed(cal_temp[39:32]);
		p1  = $signed(cal_pres_a[15:0]);
		p2  = $signed(cal_pres_a[31:16]);
		p3  = $signed(cal_pres_a[39:32]);
		p4  = $signed(cal_pres_a[47:40]);
		p5  = $signed({1'b0, cal_pres_b[15:0]});
		p6  = $signed({1'b0, cal_pres_b[31:16]});
		p7  = $signed(cal_pres_b[39:32]);
		p8  = $signed(cal_pres_b[47:40]);
		p9  = $signed(cal_pres_c[15:0]);
		p10 = $signed(cal_pres_c[23:16]);
		p11 = $signed(cal_pres_c[31:24]);
		p   = $signed({1'b0, rp});
		d   = $signed({1'b0, rt}) - t1 * 256;
		n   = d * t2 * 262144 + d * d * t3;

		num = 5 * n + 256'sd89505792 * 256'sd4294967296 + 256'sd5 * 256'sd2147483648;
		if (num < 0)
			r.kelvin = '0;
		else begin
			tk = num / (256'sd5 * 256'sd4294967296);
			r.kelvin = (tk > 256'sd33554431) ? TK_MAX : tk[TK_W-1:0];
		end

		acc = (p5 <<< 184) + ((p6 * n) <<< 127) + ((p7 * n * n) <<< 77)
			+ ((p8 * n * n * n) <<< 22) + ((p * (p1 - 16384)) <<< 161)
			+ ((p * (p2 - 16384) * n) <<< 104) + ((p * p3 * n * n) <<< 53)
			+ (p * p4 * n * n * n) + ((p * p * p9) <<< 133)
			+ ((p * p * p10 * n) <<< 85) + ((p * p * p * p11) <<< 116)
			+ (256'sd1 <<< 172);
		if (acc < 0)
			r.pascal = '0;
		else if (acc[255:PP_OVF_LSB] != 0)
			r.pascal = PP_MAX;
		else
			r.pascal = acc[PP_OVF_LSB-1:PP_LSB];
		return r;
	endfunction

	// track calibration and predict each accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp   <= '0;
			cal_pres_a <= '0;
			cal_pres_b <= '0;
			cal_pres_c <= '0;
		end else begin
			if (start && !busy) begin
				expected_readings.push_back(compensate(raw_pressure, raw_temperature));
				requests_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CAL_TEMP:   cal_temp   <= cfg_data[39:0];
					CFG_CAL_PRES_A: cal_pres_a <= cfg_data[47:0];
					CFG_CAL_PRES_B: cal_pres_b <= cfg_data[47:0];
					CFG_CAL_PRES_C: cal_pres_c <= cfg_data[31:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && done) begin
			if (expected_readings.size() == 0) begin
				errors++;
				$display("%0t unexpected reading kelvin=%0d pascal=%0d", $time,
					temperature_kelvin, pressure_pascal);
			end else begin
				exp_r = expected_readings.pop_front();
				readings_checked++;
				if (temperature_kelvin !== exp_r.kelvin) begin
					errors++;
					$display("%0t kelvin mismatch: expected %0d actual %0d", $time,
						exp_r.kelvin, temperature_kelvin);
				end
				if (pressure_pascal !== exp_r.pascal) begin
					errors++;
					$display("%0t pascal mismatch: expected %0d actual %0d", $time,
						exp_r.pascal, pressure_pascal);
				end
			end
		end
	end

	task automatic send_sample(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt);
		if (idle_pct > 0) begin
			while ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start           <= 1'b1;
		raw_pressure    <= rp;
		raw_temperature <= rt;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after its last write
	task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_cal(logic [39:0] ct, logic [47:0] pa, logic [47:0] pb,
		logic [31:0] pc);
		write_cal(CFG_CAL_TEMP, {8'h00, ct});
		write_cal(CFG_CAL_PRES_A, pa);
		write_cal(CFG_CAL_PRES_B, pb);
		write_cal(CFG_CAL_PRES_C, {16'h0000, pc});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// typical part: t1 27504 t2 26435 t3 -3, p1 -2592 p2 -1279 ...
	task automatic load_typical_cal();
		load_cal({8'hFD, 16'd26435, 16'd27504},
			{8'h00, 8'h03, 16'hFB01, 16'hF5E0},
			{8'hFF, 8'h0C, 16'd28960, 16'd19972},
			{8'h00, 8'h05, 16'd4516});
	endtask

	task automatic load_jittered_cal();
		load_cal({8'hFD + 8'($urandom_range(6)), 16'd26435 + 16'($urandom_range(400)),
				16'd27400 + 16'($urandom_range(200))},
			{8'($urandom_range(255)), 8'($urandom_range(255)),
				16'hFB00 + 16'($urandom_range(511)), 16'hF500 + 16'($urandom_range(511))},
			{8'($urandom_range(255)), 8'($urandom_range(255)),
				16'd28900 + 16'($urandom_range(120)), 16'd19900 + 16'($urandom_range(150))},
			{8'($urandom_range(255)), 8'($urandom_range(255)), 16'($urandom)});
	endtask

	task automatic test_reset_calibration();
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample(24'h800000, 24'h6B7000);
		drain();
	endtask

	task automatic test_directed_extremes();
		load_cal('1, '1, '1, '1);
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample('1, '0);
		drain();
		// sign bits of every signed coefficient set, unsigned ones at max except t1 at zero
		load_cal({8'h80, 16'hFFFF, 16'h0000}, {8'h80, 8'h80, 16'h8000, 16'h8000},
			{8'h80, 8'h80, 16'hFFFF, 16'hFFFF}, {8'h80, 8'h80, 16'h8000});
		send_sample('1, '1);
		send_sample('0, '1);
		send_sample(24'h000001, 24'hFFFFFE);
		drain();
		load_cal({8'h7F, 16'hFFFF, 16'hFFFF}, {8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF},
			{8'h7F, 8'h7F, 16'h0000, 16'h0000}, {8'h7F, 8'h7F, 16'h7FFF});
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample(24'h5A5A5A, 24'hA5A5A5);
		drain();
		load_typical_cal();
		send_sample(24'h6E0000, 24'h7F0000);
		send_sample(24'h640000, 24'h6B8000);
		send_sample('0, '0);
		send_sample('1, '1);
		send_sample('1, '0);
		send_sample('0, '1);
		drain();
	endtask

	task automatic test_unknown_index();
		logic [CFG_IDX_W-1:0] idx;
		for (int i = 4; i < (1 << CFG_IDX_W); i++) begin
			idx = CFG_IDX_W'(i);
			write_cal(idx, '1);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_sample(24'h6E0000, 24'h7F0000);
		send_sample('1, '0);
		drain();
	endtask

	task automatic test_random_samples(int pct, int count);
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				drain();
				if ($urandom_range(4) == 0)
					load_cal(40'({$urandom, $urandom}), 48'({$urandom, $urandom}),
						48'({$urandom, $urandom}), $urandom);
				else
					load_jittered_cal();
			end
			if ($urandom_range(9) < 7)
				send_sample(24'h500000 + 24'($urandom_range(24'h300000)),
					24'h600000 + 24'($urandom_range(24'h300000)));
			else
				send_sample(24'($urandom), 24'($urandom));
		end
		drain();
		idle_pct = 0;
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		raw_pressure     = '0;
		raw_temperature  = '0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		errors           = 0;
		requests_sent    = 0;
		readings_checked = 0;
		idle_pct         = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_calibration();
		test_directed_extremes();
		test_unknown_index();
		test_random_samples(0, 280);
		test_random_samples(62, 240);
		test_random_samples(17, 240);
		test_random_samples(0, 160);

		$display("covered %0d requests, %0d readings checked, over reset, extreme,",
			requests_sent, readings_checked);
		$display("typical and random calibrations with back-to-back and gapped requests");
		if (errors == 0 && expected_readings.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bptc_pkg.sv
rtl/bptc_delay.sv
rtl/bptc_mul.sv
rtl/bptc_front.sv
rtl/baro_pressure_temp_compensation.sv
sim/baro_pressure_temp_compensation_test.sv
